@@ design/dhc_ftx_pkg.sv @@
`default_nettype none

package dhc_ftx_pkg;

    localparam int unsigned DEF_MAX_PACKET_WORDS  = 16 * 1024 * 1024;
    localparam int unsigned DEF_HEADER_SKIP_WORDS = 5;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned POS_W  = 25;

    localparam logic [WORD_W-1:0] MAGIC_WORD       = 32'hCAFE_BABE;
    localparam logic [3:0]        START_TYPE       = 4'hB;
    localparam logic [POS_W-1:0]  MIN_PACKET_WORDS = 25'd4;
    localparam logic [POS_W-1:0]  POS_MAX          = 25'h1FF_FFFF;

    typedef enum logic [2:0] {
        ST_FOUND      = 3'd0,
        ST_NO_START   = 3'd1,
        ST_BAD_MAGIC  = 3'd2,
        ST_BAD_LENGTH = 3'd3,
        ST_OVERRUN    = 3'd4,
        ST_BAD_SIZE   = 3'd5
    } status_t;

    typedef enum logic [7:0] {
        PH_SKIP   = 8'b0000_0001,
        PH_MAGIC  = 8'b0000_0010,
        PH_LENGTH = 8'b0000_0100,
        PH_IGN1   = 8'b0000_1000,
        PH_IGN2   = 8'b0001_0000,
        PH_BODY   = 8'b0010_0000,
        PH_START  = 8'b0100_0000,
        PH_TAIL   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [WORD_W-1:0] data_word;
        logic [POS_W-1:0]  packet_words;
        logic              first_word;
        logic              last_word;
    } in_item_t;

    typedef struct packed {
        status_t           status;
        logic [WORD_W-1:0] trigger_number;
        logic [WORD_W-1:0] trigger_tag;
    } result_t;

endpackage

`default_nettype wire

@@ design/dhc_ftx_parser.sv @@
`default_nettype none

module dhc_ftx_parser #(
    parameter int unsigned MAX_PACKET_WORDS  = dhc_ftx_pkg::DEF_MAX_PACKET_WORDS,
    parameter int unsigned HEADER_SKIP_WORDS = dhc_ftx_pkg::DEF_HEADER_SKIP_WORDS
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 step,
    input  wire dhc_ftx_pkg::in_item_t item,
    output logic                      res_valid,
    output dhc_ftx_pkg::result_t      res
);
    import dhc_ftx_pkg::*;

    localparam logic [POS_W-1:0] SKIP_INIT = POS_W'(HEADER_SKIP_WORDS);
    localparam logic [POS_W-1:0] MAX_LEN   = POS_W'(MAX_PACKET_WORDS);

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  len_reg, len_next;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  left_reg, left_next;
    logic [1:0]        bidx_reg, bidx_next;
    logic              parsable_reg, parsable_next;
    logic [WORD_W-1:0] ptrig_reg, ptrig_next;
    logic              done_reg, done_next;

    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] w;
    logic [32:0]       ovr_lhs;
    logic [32:0]       ovr_rhs;
    logic [32:0]       len_round;
    logic [25:0]       pos_plus3;

    function automatic phase_t at_boundary(input logic [25:0] next_pos,
                                           input logic [POS_W-1:0] len);
        logic [26:0] end_pos;
        end_pos = {1'b0, next_pos} + 27'd4;
        return (end_pos <= 27'(len)) ? PH_MAGIC : PH_TAIL;
    endfunction

    assign w         = item.data_word;
    assign len_round = 33'(w) + 33'd3;

    always_comb begin
        pos           = pos_reg;
        len_next      = len_reg;
        phase_next    = phase_reg;
        left_next     = left_reg;
        bidx_next     = bidx_reg;
        parsable_next = parsable_reg;
        ptrig_next    = ptrig_reg;
        done_next     = done_reg;
        res_valid     = 1'b0;
        res           = '{status: ST_FOUND, trigger_number: '0, trigger_tag: '0};

        if (item.first_word) begin
            pos           = '0;
            len_next      = item.packet_words;
            done_next     = 1'b0;
            ptrig_next    = '0;
            bidx_next     = '0;
            parsable_next = 1'b0;
            left_next     = SKIP_INIT;
            phase_next    = (SKIP_INIT != '0) ? PH_SKIP : at_boundary(26'd0, item.packet_words);
            if (item.packet_words == '0 || item.packet_words > MAX_LEN ||
                item.packet_words < MIN_PACKET_WORDS) begin
                res_valid  = 1'b1;
                res.status = ST_BAD_SIZE;
                done_next  = 1'b1;
            end
        end

        pos_plus3 = {1'b0, pos} + 26'd3;
        ovr_lhs   = 33'({pos_plus3, 2'b00}) + 33'(w);
        ovr_rhs   = 33'({len_next, 2'b00});

        if (!done_next && pos < len_next) begin
            unique case (phase_next)
                PH_SKIP: begin
                    if (left_next != '0) begin
                        left_next = left_next - 1'b1;
                    end
                    if (left_next == '0) begin
                        phase_next = at_boundary({1'b0, pos} + 26'd1, len_next);
                    end
                end
                PH_MAGIC: begin
                    if (w != MAGIC_WORD) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_MAGIC;
                        done_next  = 1'b1;
                    end else begin
                        phase_next = PH_LENGTH;
                    end
                end
                PH_LENGTH: begin
                    if (w == '0 || w[31]) begin
                        res_valid  = 1'b1;
                        res.status = ST_BAD_LENGTH;
                        done_next  = 1'b1;
                    end else if (ovr_lhs > ovr_rhs) begin
                        res_valid  = 1'b1;
                        res.status = ST_OVERRUN;
                        done_next  = 1'b1;
                    end else begin
                        parsable_next = (w[1:0] == 2'b00);
                        left_next     = len_round[26:2];
                        bidx_next     = 2'd0;
                        phase_next    = PH_IGN1;
                    end
                end
                PH_IGN1: begin
                    phase_next = PH_IGN2;
                end
                PH_IGN2: begin
                    phase_next = PH_BODY;
                end
                PH_BODY: begin
                    if (parsable_next && bidx_next == 2'd0 && w[14:11] == START_TYPE) begin
                        ptrig_next = {16'h0000, w[31:16]};
                        bidx_next  = 2'd1;
                        phase_next = PH_START;
                    end else begin
                        bidx_next = 2'd1;
                        if (left_next != '0) begin
                            left_next = left_next - 1'b1;
                        end
                        if (left_next == '0) begin
                            phase_next = at_boundary({1'b0, pos} + 26'd1, len_next);
                        end
                    end
                end
                PH_START: begin
                    if (bidx_next == 2'd1) begin
                        ptrig_next = ptrig_next | {w[15:0], 16'h0000};
                        bidx_next  = 2'd2;
                    end else if (bidx_next == 2'd2) begin
                        bidx_next = 2'd3;
                    end else begin
                        res_valid          = 1'b1;
                        res.status         = ST_FOUND;
                        res.trigger_number = ptrig_next;
                        res.trigger_tag    = {w[15:0], w[31:16]};
                        done_next          = 1'b1;
                    end
                end
                PH_TAIL: begin
                end
                default: begin
                end
            endcase
        end

        pos_next = (pos < POS_MAX) ? pos + 1'b1 : pos;

        if (item.last_word && !done_next) begin
            res_valid = 1'b1;
            done_next = 1'b1;
            if (phase_next == PH_START) begin
                res.status         = ST_FOUND;
                res.trigger_number = ptrig_next;
            end else begin
                res.status = ST_NO_START;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            len_reg      <= '0;
            phase_reg    <= PH_SKIP;
            left_reg     <= '0;
            bidx_reg     <= '0;
            parsable_reg <= 1'b0;
            ptrig_reg    <= '0;
            done_reg     <= 1'b0;
        end else if (step) begin
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            phase_reg    <= phase_next;
            left_reg     <= left_next;
            bidx_reg     <= bidx_next;
            parsable_reg <= parsable_next;
            ptrig_reg    <= ptrig_next;
            done_reg     <= done_next;
        end
    end

endmodule

`default_nettype wire

@@ design/dhc_ftx_out_stage.sv @@
`default_nettype none

module dhc_ftx_out_stage (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 load,
    input  wire dhc_ftx_pkg::result_t res_in,
    input  wire logic                 m_ready,
    output logic                      m_valid,
    output dhc_ftx_pkg::result_t      res_out,
    output logic                      can_take
);
    import dhc_ftx_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    assign can_take = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign res_out  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= res_in;
        end
    end

endmodule

`default_nettype wire

@@ design/dhc_frame_trigger_extractor.sv @@
`default_nettype none

// Channel   Direction  Ports
// -------   ---------  -----------------------------------------------------------
// s_        in         s_valid s_ready s_data_word s_packet_words s_first_word s_last_word
// m_        out        m_valid m_ready m_status m_trigger_number m_trigger_tag
//
// One item per cycle while the result register is not stalled; the parse state updates
// as an item leaves the input register, and any result it yields loads the result register.
// A result passes from the input register to the result register; zero or one result per item.
// Reset clears all control and parse state.
// A stalled result holds the next item in the input register; s_ready then drops.

module dhc_frame_trigger_extractor #(
    parameter int unsigned MAX_PACKET_WORDS  = dhc_ftx_pkg::DEF_MAX_PACKET_WORDS,
    parameter int unsigned HEADER_SKIP_WORDS = dhc_ftx_pkg::DEF_HEADER_SKIP_WORDS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_data_word,
    input  wire logic [24:0] s_packet_words,
    input  wire logic        s_first_word,
    input  wire logic        s_last_word,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [2:0]       m_status,
    output logic [31:0]      m_trigger_number,
    output logic [31:0]      m_trigger_tag
);
    import dhc_ftx_pkg::*;

    logic     in_valid_reg;
    in_item_t in_item_reg;
    logic     advance;
    logic     can_take;
    logic     res_valid;
    result_t  res;
    result_t  res_out;

    assign advance = in_valid_reg && can_take;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{data_word: s_data_word, packet_words: s_packet_words,
                             first_word: s_first_word, last_word: s_last_word};
        end
    end

    dhc_ftx_parser #(
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS),
        .HEADER_SKIP_WORDS(HEADER_SKIP_WORDS)
    ) u_parser (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .item     (in_item_reg),
        .res_valid(res_valid),
        .res      (res)
    );

    dhc_ftx_out_stage u_out (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (advance && res_valid),
        .res_in  (res),
        .m_ready (m_ready),
        .m_valid (m_valid),
        .res_out (res_out),
        .can_take(can_take)
    );

    assign m_status         = res_out.status;
    assign m_trigger_number = res_out.trigger_number;
    assign m_trigger_tag    = res_out.trigger_tag;

    a_fields_zero_unless_found: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_FOUND) |-> (m_trigger_number == '0 && m_trigger_tag == '0))
        else $error("trigger fields nonzero on error status");

    a_result_needs_item: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(in_valid_reg))
        else $error("result without a buffered item");

    a_ready_when_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !m_valid) |-> s_ready)
        else $error("input stalled while result register is free");

endmodule

`default_nettype wire

@@ sim/tb_dhc_frame_trigger_extractor.sv @@
module tb_dhc_frame_trigger_extractor;
    import dhc_ftx_pkg::*;

    localparam int unsigned SKIP_WORDS = DEF_HEADER_SKIP_WORDS;
    localparam int unsigned MAX_WORDS  = DEF_MAX_PACKET_WORDS;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic [31:0] s_data_word      = '0;
    logic [24:0] s_packet_words   = '0;
    logic        s_first_word     = 1'b0;
    logic        s_last_word      = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_trigger_number;
    logic [31:0] m_trigger_tag;

    in_item_t    pending_words[$];
    result_t     expected_results[$];
    bit          in_taken;
    bit          calm;
    int unsigned error_count;
    int unsigned words_made;

    // parser state tracked alongside the block
    logic [24:0] cur_pos;
    logic [24:0] cur_len;
    phase_t      cur_phase;
    logic [31:0] frame_left;
    logic [1:0]  body_idx;
    bit          frame_ok;
    logic [31:0] trig_acc;
    bit          pkt_closed;

    dhc_frame_trigger_extractor i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_word      (s_data_word),
        .s_packet_words   (s_packet_words),
        .s_first_word     (s_first_word),
        .s_last_word      (s_last_word),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_trigger_number (m_trigger_number),
        .m_trigger_tag    (m_trigger_tag)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic phase_t frame_or_tail(input longint unsigned nxt);
        return (nxt + 4 <= longint'(cur_len)) ? PH_MAGIC : PH_TAIL;
    endfunction

    task automatic report(input status_t st, input logic [31:0] num, input logic [31:0] tag);
        expected_results.push_back(result_t'{st, num, tag});
        pkt_closed = 1'b1;
    endtask

    task automatic parse_word(input in_item_t it);
        logic [24:0] p;
        logic [31:0] w;
        w = it.data_word;
        if (it.first_word) begin
            cur_pos    = '0;
            cur_len    = it.packet_words;
            pkt_closed = 1'b0;
            trig_acc   = '0;
            body_idx   = '0;
            frame_ok   = 1'b0;
            frame_left = SKIP_WORDS;
            cur_phase  = (frame_left != 0) ? PH_SKIP : frame_or_tail(64'd0);
            if (it.packet_words == 0 || it.packet_words > MAX_WORDS ||
                it.packet_words < MIN_PACKET_WORDS)
                report(ST_BAD_SIZE, '0, '0);
        end
        if (!pkt_closed && cur_pos < cur_len) begin
            p = cur_pos;
            case (cur_phase)
                PH_SKIP: begin
                    if (frame_left != 0) frame_left--;
                    if (frame_left == 0) cur_phase = frame_or_tail(longint'(p) + 1);
                end
                PH_MAGIC: begin
                    if (w != MAGIC_WORD) report(ST_BAD_MAGIC, '0, '0);
                    else cur_phase = PH_LENGTH;
                end
                PH_LENGTH: begin
                    if (w == 0 || w[31]) begin
                        report(ST_BAD_LENGTH, '0, '0);
                    end else if ((longint'(p) + 3) * 4 + longint'(w) > longint'(cur_len) * 4) begin
                        report(ST_OVERRUN, '0, '0);
                    end else begin
                        frame_ok   = (w[1:0] == 2'b00);
                        frame_left = (w + 3) >> 2;
                        body_idx   = '0;
                        cur_phase  = PH_IGN1;
                    end
                end
                PH_IGN1: cur_phase = PH_IGN2;
                PH_IGN2: cur_phase = PH_BODY;
                PH_BODY: begin
                    if (frame_ok && body_idx == 0 && w[14:11] == START_TYPE) begin
                        trig_acc  = {16'h0, w[31:16]};
                        body_idx  = 2'd1;
                        cur_phase = PH_START;
                    end else begin
                        body_idx = 2'd1;
                        if (frame_left != 0) frame_left--;
                        if (frame_left == 0) cur_phase = frame_or_tail(longint'(p) + 1);
                    end
                end
                PH_START: begin
                    if (body_idx == 1) begin
                        trig_acc = trig_acc | {w[15:0], 16'h0};
                        body_idx = 2'd2;
                    end else if (body_idx == 2) begin
                        body_idx = 2'd3;
                    end else begin
                        report(ST_FOUND, trig_acc, {w[15:0], w[31:16]});
                    end
                end
                default: ;
            endcase
        end
        if (cur_pos < POS_MAX) cur_pos++;
        if (it.last_word && !pkt_closed) begin
            if (cur_phase == PH_START) report(ST_FOUND, trig_acc, '0);
            else report(ST_NO_START, '0, '0);
        end
    endtask

    task automatic push_word(input logic [31:0] d, input logic [24:0] pw, input bit first,
                             input bit last);
        pending_words.push_back(in_item_t'{d, pw, first, last});
    endtask

    task automatic send_packet();
        logic [31:0] words[$];
        logic [31:0] w;
        logic [24:0] declared;
        int          frames, start_at, bad_kind, bad_at, nbody, nbytes, size_kind, stop, n;
        bit          with_last;
        // stray words between packets
        if ($urandom_range(99) < 6) begin
            repeat ($urandom_range(1, 3))
                push_word($urandom, 25'($urandom), 1'b0, $urandom_range(99) < 40);
        end
        repeat (SKIP_WORDS) words.push_back($urandom);
        frames   = $urandom_range(1, 2);
        start_at = ($urandom_range(99) < 75) ? $urandom_range(0, frames - 1) : -1;
        bad_kind = $urandom_range(99);
        bad_at   = $urandom_range(0, frames - 1);
        for (int f = 0; f < frames; f++) begin
            nbody  = $urandom_range(1, 4);
            nbytes = nbody * 4;
            if (f != start_at && $urandom_range(99) < 20) nbytes -= $urandom_range(1, 3);
            w = MAGIC_WORD;
            if (f == bad_at && bad_kind < 6) begin
                w = $urandom;
                if (w == MAGIC_WORD) w[0] = ~w[0];
            end
            words.push_back(w);
            w = nbytes;
            if (f == bad_at && bad_kind >= 6 && bad_kind < 12)
                w = ($urandom_range(1) != 0) ? 32'd0 : {1'b1, 31'($urandom)};
            else if (f == bad_at && bad_kind >= 12 && bad_kind < 18)
                w = 4 * $urandom_range(64, 400) + $urandom_range(0, 3);
            words.push_back(w);
            words.push_back($urandom);
            words.push_back($urandom);
            for (int b = 0; b < nbody; b++) begin
                w = $urandom;
                if (b == 0) begin
                    if (f == start_at || (nbytes % 4 != 0 && $urandom_range(1) != 0))
                        w[14:11] = START_TYPE;
                    else if (w[14:11] == START_TYPE)
                        w[11] = ~w[11];
                end
                words.push_back(w);
            end
        end
        repeat ($urandom_range(0, 2)) words.push_back($urandom);

        n         = words.size();
        size_kind = $urandom_range(99);
        if (size_kind < 68) begin
            declared = 25'(n);
        end else if (size_kind < 76) begin
            declared = 25'(n - $urandom_range(1, 6));
        end else if (size_kind < 84) begin
            declared = 25'(n + $urandom_range(1, 20));
        end else if (size_kind < 88) begin
            declared = 25'(MAX_WORDS);
        end else begin
            if (size_kind < 92) declared = '0;
            else if (size_kind < 96) declared = 25'($urandom_range(1, 3));
            else declared = 25'($urandom_range(MAX_WORDS + 1, POS_MAX));
            n = $urandom_range(1, 3);
        end

        stop      = n - 1;
        with_last = 1'b1;
        if ($urandom_range(99) < 8) with_last = 1'b0;
        else if ($urandom_range(99) < 9) stop = $urandom_range(0, n - 1);
        for (int i = 0; i <= stop; i++)
            push_word(words[i], (i == 0) ? declared : 25'($urandom), i == 0,
                      with_last && i == stop);
        words_made += stop + 1;
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
    endtask

    always @(negedge aclk) begin : drive
        in_item_t nxt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || in_taken) begin
            if (pending_words.size() != 0 && (calm || $urandom_range(99) >= 18)) begin
                nxt = pending_words.pop_front();
                s_valid        <= 1'b1;
                s_data_word    <= nxt.data_word;
                s_packet_words <= nxt.packet_words;
                s_first_word   <= nxt.first_word;
                s_last_word    <= nxt.last_word;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= aresetn && (calm || $urandom_range(99) >= 18);
    end

    always @(posedge aclk) begin : watch
        result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: status %0d number %h tag %h",
                           m_status, m_trigger_number, m_trigger_tag);
                    error_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        error_count++;
                    end
                    if (m_trigger_number !== want.trigger_number) begin
                        $error("trigger_number: expected %h, actual %h",
                               want.trigger_number, m_trigger_number);
                        error_count++;
                    end
                    if (m_trigger_tag !== want.trigger_tag) begin
                        $error("trigger_tag: expected %h, actual %h",
                               want.trigger_tag, m_trigger_tag);
                        error_count++;
                    end
                end
            end
            in_taken = s_valid && s_ready;
            if (in_taken)
                parse_word(in_item_t'{s_data_word, s_packet_words, s_first_word, s_last_word});
        end else begin
            in_taken = 1'b0;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    initial begin
        #3000000;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        cur_pos    = '0;
        cur_len    = '0;
        cur_phase  = PH_SKIP;
        frame_left = '0;
        body_idx   = '0;
        frame_ok   = 1'b0;
        trig_acc   = '0;
        pkt_closed = 1'b0;

        // last word before any first word
        push_word(32'h0000_0000, 25'h000_0000, 1'b0, 1'b1);
        // bad sizes: zero, top of range, below minimum with trailing words ignored
        push_word(32'h0000_0000, 25'd0, 1'b1, 1'b1);
        push_word(32'hFFFF_FFFF, POS_MAX, 1'b1, 1'b0);
        push_word(32'h5A5A_5A5A, 25'd3, 1'b1, 1'b0);
        push_word(32'hA5A5_A5A5, 25'h0AA_AAAA, 1'b0, 1'b1);
        // one-word start frame, body 1..3 taken from past its end
        push_word(32'h0000_0000, 25'd13, 1'b1, 1'b0);
        push_word(32'hFFFF_FFFF, 25'h155_5555, 1'b0, 1'b0);
        repeat (3) push_word($urandom, 25'($urandom), 1'b0, 1'b0);
        push_word(MAGIC_WORD, 25'($urandom), 1'b0, 1'b0);
        push_word(32'd4, 25'($urandom), 1'b0, 1'b0);
        push_word(32'hFFFF_FFFF, 25'($urandom), 1'b0, 1'b0);
        push_word(32'h0000_0000, 25'($urandom), 1'b0, 1'b0);
        push_word(32'hFFFF_DFFF, 25'($urandom), 1'b0, 1'b0);
        push_word(32'h0000_8001, 25'($urandom), 1'b0, 1'b0);
        push_word($urandom, 25'($urandom), 1'b0, 1'b0);
        push_word(32'h1234_ABCD, 25'($urandom), 1'b0, 1'b1);
        // largest legal size, ends early
        push_word($urandom, 25'(MAX_WORDS), 1'b1, 1'b0);
        push_word($urandom, 25'($urandom), 1'b0, 1'b1);
        // short tail: too few words left for a frame header
        push_word($urandom, 25'd6, 1'b1, 1'b0);
        repeat (4) push_word($urandom, 25'($urandom), 1'b0, 1'b0);
        push_word($urandom, 25'($urandom), 1'b0, 1'b1);
        wait_drained();

        while (words_made < 160) send_packet();
        wait_drained();
        calm = 1'b1;
        while (words_made < 280) send_packet();
        while (pending_words.size() != 0) @(posedge aclk);
        calm = 1'b0;
        while (words_made < 450) send_packet();

        wait_drained();
        repeat (12) @(posedge aclk);
        if (error_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
